// ===== rtl/core/svptb_pkg.sv =====
`timescale 1ns / 1ps

package svptb_pkg;

	localparam int POOL_PAGES_DEF = 64;
	localparam int IDX_W          = 9;
	localparam int ENTRIES_PER_PG = 512;
	localparam int VPN_W          = 27;
	localparam int PPN_W          = 44;
	localparam int CNT_W          = 28;
	localparam int PERM_W         = 8;
	localparam int ENTRY_W        = 54;

	localparam logic KIND_MAP    = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD2,
		ST_CK2,
		ST_CK1,
		ST_LEAF,
		ST_CK0
	} svptb_state_t;

	typedef struct packed {
		logic             status;
		logic             is_mapped;
		logic [CNT_W-1:0] pages_mapped;
	} svptb_res_t;

endpackage

// ===== rtl/core/svptb_ram.sv =====
`timescale 1ns / 1ps

module svptb_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 32768,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/svptb_walk.sv =====
`timescale 1ns / 1ps

module svptb_walk import svptb_pkg::*; #(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	parameter int DEPTH = POOL_PAGES * ENTRIES_PER_PG,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PPN_W-1:0]   base_ppn,
	input  logic               start,
	input  logic               kind,
	input  logic [VPN_W-1:0]   vpn,
	input  logic [PPN_W-1:0]   ppn,
	input  logic [CNT_W-1:0]   page_count,
	input  logic [PERM_W-1:0]  perm,
	output logic               busy,
	output logic               res_vld,
	output svptb_res_t         res,
	output logic               mem_we,
	output logic [ADDR_W-1:0]  mem_waddr,
	output logic [ENTRY_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0]  mem_raddr,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	localparam int PAGE_W = ADDR_W - IDX_W;
	localparam int NFP_W  = $clog2(POOL_PAGES + 1);

	svptb_state_t state_q, state_d;

	logic              kind_q;
	logic [VPN_W-1:0]  vpn_q;
	logic [PPN_W-1:0]  ppn_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PERM_W-1:0] perm_q;
	logic [CNT_W-1:0]  done_cnt_q;
	logic [PAGE_W-1:0] l1_q;
	logic [PAGE_W-1:0] l0_q;
	logic [NFP_W-1:0]  nfp_q;
	logic [ADDR_W-1:0] clr_q;
	logic              res_vld_q;
	svptb_res_t        res_q;

	logic [IDX_W-1:0]  idx2, idx1, idx0;
	logic [PPN_W-1:0]  ptr_page;
	logic              ent_v;
	logic              ptr_in;
	logic              pool_left;
	logic              lvl_ok;
	logic              alloc;
	logic [PAGE_W-1:0] lvl_pg;
	logic [CNT_W-1:0]  done_inc;
	logic              last_page;
	logic              clr_last;

	logic       fin;
	svptb_res_t fin_res;

	assign idx2 = vpn_q[3*IDX_W-1:2*IDX_W];
	assign idx1 = vpn_q[2*IDX_W-1:IDX_W];
	assign idx0 = vpn_q[IDX_W-1:0];

	// Entry just read: follow a valid pointer, or on a map allocate a fresh table.
	always_comb begin
		ent_v     = mem_rdata[0];
		ptr_page  = mem_rdata[ENTRY_W-1:ENTRY_W-PPN_W] - base_ppn;
		ptr_in    = ptr_page < PPN_W'(nfp_q);
		pool_left = nfp_q < NFP_W'(POOL_PAGES);
		lvl_ok    = ent_v ? ptr_in : ((kind_q == KIND_MAP) && pool_left);
		alloc     = !ent_v && (kind_q == KIND_MAP) && pool_left;
		lvl_pg    = ent_v ? ptr_page[PAGE_W-1:0] : nfp_q[PAGE_W-1:0];
		done_inc  = done_cnt_q + CNT_W'(1);
		last_page = done_inc == cnt_q;
		clr_last  = clr_q == ADDR_W'(DEPTH - 1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && (kind == KIND_LOOKUP || page_count != '0)) begin
					state_d = ST_RD2;
				end
			end
			ST_RD2: state_d = ST_CK2;
			ST_CK2: state_d = lvl_ok ? ST_CK1 : ST_IDLE;
			ST_CK1: begin
				if (!lvl_ok) begin
					state_d = ST_IDLE;
				end else if (kind_q == KIND_LOOKUP) begin
					state_d = ST_CK0;
				end else begin
					state_d = ST_LEAF;
				end
			end
			ST_LEAF: state_d = last_page ? ST_IDLE : ST_RD2;
			ST_CK0: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		fin       = 1'b0;
		fin_res   = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				// A map of zero pages finishes at once.
				fin = start && (kind == KIND_MAP) && (page_count == '0);
			end
			ST_RD2: begin
				mem_raddr = {PAGE_W'(0), idx2};
			end
			ST_CK2: begin
				mem_raddr = {lvl_pg, idx1};
				mem_we    = alloc;
				mem_waddr = {PAGE_W'(0), idx2};
				mem_wdata = {base_ppn + PPN_W'(nfp_q), (IDX_W)'(0), 1'b1};
				fin       = !lvl_ok;
				fin_res.status       = kind_q == KIND_MAP;
				fin_res.pages_mapped = done_cnt_q;
			end
			ST_CK1: begin
				mem_raddr = {lvl_pg, idx0};
				mem_we    = alloc;
				mem_waddr = {l1_q, idx1};
				mem_wdata = {base_ppn + PPN_W'(nfp_q), (IDX_W)'(0), 1'b1};
				fin       = !lvl_ok;
				fin_res.status       = kind_q == KIND_MAP;
				fin_res.pages_mapped = done_cnt_q;
			end
			ST_LEAF: begin
				mem_we    = 1'b1;
				mem_waddr = {l0_q, idx0};
				mem_wdata = {ppn_q, 2'b00, perm_q};
				fin       = last_page;
				fin_res.pages_mapped = done_inc;
			end
			ST_CK0: begin
				fin = 1'b1;
				fin_res.is_mapped = mem_rdata[0];
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			nfp_q      <= NFP_W'(1);
			clr_q      <= '0;
			res_vld_q  <= 1'b0;
			done_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= fin;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				ST_IDLE: begin
					if (start) begin
						done_cnt_q <= '0;
					end
				end
				ST_CK2: begin
					if (alloc) begin
						nfp_q <= nfp_q + NFP_W'(1);
					end
				end
				ST_CK1: begin
					if (alloc) begin
						nfp_q <= nfp_q + NFP_W'(1);
					end
				end
				ST_LEAF: done_cnt_q <= done_inc;
				default: begin
					done_cnt_q <= done_cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fin_res;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q <= kind;
					vpn_q  <= vpn;
					ppn_q  <= ppn;
					cnt_q  <= page_count;
					perm_q <= perm;
				end
			end
			ST_CK2: l1_q <= lvl_pg;
			ST_CK1: l0_q <= lvl_pg;
			ST_LEAF: begin
				vpn_q <= vpn_q + VPN_W'(1);
				ppn_q <= ppn_q + PPN_W'(1);
			end
			default: begin
				l1_q <= l1_q;
			end
		endcase
	end

	assign busy    = state_q != ST_IDLE;
	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

// ===== rtl/core/sv39_page_table_builder_unit.sv =====
`timescale 1ns / 1ps

// Sv39 page table builder. The three-level table lives in one pool of POOL_PAGES
// table pages of 512 entries in a single RAM with one write and one registered
// read port; page zero is the root and new tables are handed out in order. After
// reset the RAM is swept to zero, one entry per cycle, with busy high; configuration
// writes are taken throughout. A lookup issues the root read, checks each of the three
// levels as its read returns, and registers the result. For each page mapped, a map
// run issues the root read, checks the root entry and issues the middle read, checks
// the middle entry and writes the leaf; done is high in the cycle after the last leaf
// write. A run of zero pages shows done in the cycle right after the transfer, and a
// stopped run ends at the failing level. busy is low in the cycle that shows done, so
// the next start transfer can be taken at the edge that ends it.
// The result is shown for one cycle with done and cannot be held off.
module sv39_page_table_builder_unit import svptb_pkg::*; #(
	parameter int POOL_PAGES = POOL_PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [VPN_W-1:0]   vpn,
	input  logic [PPN_W-1:0]   ppn,
	input  logic [CNT_W-1:0]   page_count,
	input  logic [PERM_W-1:0]  perm,
	output logic               done,
	output logic               status,
	output logic               is_mapped,
	output logic [CNT_W-1:0]   pages_mapped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [PPN_W-1:0]   cfg_wdata
);

	localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_PG;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [PPN_W-1:0]   base_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;
	logic               res_vld;
	svptb_res_t         res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_wdata;
		end
	end

	svptb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	svptb_walk #(
		.POOL_PAGES(POOL_PAGES),
		.DEPTH     (DEPTH),
		.ADDR_W    (ADDR_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_ppn  (base_q),
		.start     (start),
		.kind      (kind),
		.vpn       (vpn),
		.ppn       (ppn),
		.page_count(page_count),
		.perm      (perm),
		.busy      (busy),
		.res_vld   (res_vld),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign done         = res_vld;
	assign status       = res.status;
	assign is_mapped    = res.is_mapped;
	assign pages_mapped = res.pages_mapped;

`ifndef ASSERT_OFF
	// An accepted item either answers at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither busy nor answered");

	// A lookup result that shows a mapping never carries a stop flag or a page count.
	a_lookup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_mapped |-> !status && pages_mapped == '0)
		else $error("lookup result mixed with map fields");

	// A result only follows a transfer or work in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without work");
`endif

endmodule
